FILE: rtl/spdm_pkg.sv
// Shared constants for the stereo peak dB meter.
package spdm_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int SEGMENTS     = 60;

  // Log2 datapath: Q16 result, mantissa in Q1.30 (31 bits).
  localparam int FRAC_BITS = 16;
  localparam int MANT_W    = 31;

  // Result field widths and scale.
  localparam int LEVEL_W   = 10;
  localparam int SEG_W     = 6;
  localparam int LEVEL_MAX = 960;

  // round(16 * 20 * log10(2) * 2^16): Q16 log2 units to 1/16 dB.
  localparam int DB_SCALE_W = 23;
  localparam logic [DB_SCALE_W-1:0] DB_Q16_SCALE = 23'd6313057;

  // ceil(2^30 / 960); exact floor division for products below about 1.19e6.
  localparam int SEG_SHIFT = 30;
  localparam int SEG_RECIP = 1118482;

  // Pipeline depth: capture, normalize + squaring, attenuation, level, output.
  localparam int LOG_STAGES = FRAC_BITS + 1;
  localparam int LVL_STAGES = 3;
  localparam int N_STAGES   = 1 + LOG_STAGES + LVL_STAGES;

endpackage

FILE: rtl/spdm_if.sv
// Valid/ready channel interfaces for sample pairs and meter readings.
interface spdm_in_if #(
  parameter int SAMPLE_WIDTH = spdm_pkg::SAMPLE_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_sample;
  logic signed [SAMPLE_WIDTH-1:0] right_sample;
  logic                           last_in_block;

  modport source (output valid, left_sample, right_sample, last_in_block, input ready);
  modport sink   (input valid, left_sample, right_sample, last_in_block, output ready);
endinterface

interface spdm_out_if;
  logic                         valid;
  logic                         ready;
  logic [spdm_pkg::LEVEL_W-1:0] left_level;
  logic [spdm_pkg::LEVEL_W-1:0] right_level;
  logic [spdm_pkg::SEG_W-1:0]   left_lit_segments;
  logic [spdm_pkg::SEG_W-1:0]   right_lit_segments;

  modport source (output valid, left_level, right_level, left_lit_segments,
                  right_lit_segments, input ready);
  modport sink   (input valid, left_level, right_level, left_lit_segments,
                  right_lit_segments, output ready);
endinterface

FILE: rtl/stereo_peak_db_meter.sv
// Top level of the stereo peak dB meter: peak tracking, pipeline control, result channel.
//
// Accepts one stereo sample pair per clock and folds each channel's absolute
// value into a running peak. The pair marked last_in_block counts toward the
// peak, then both peaks clear and the finished peaks enter a 21-stage pipeline
// that yields one reading: the level in 1/16 dB above -60 dBFS (0..960) and
// the number of fully lit segments out of SEGMENTS. Most of the pipeline
// depth comes from the sixteen squaring stages of the log2 unit, one per
// fraction bit. Sustained rate is one pair per cycle; a stalled result only
// holds back input once every pipeline stage is occupied. A zero peak reads
// as level 0 with no segment lit, and the most negative sample reads as
// full scale.
module stereo_peak_db_meter #(
  parameter int SAMPLE_WIDTH = spdm_pkg::SAMPLE_WIDTH,
  parameter int SEGMENTS     = spdm_pkg::SEGMENTS
) (
  input  logic         clk,
  input  logic         rst_n,
  spdm_in_if.sink      in_ch,
  spdm_out_if.source   out_ch
);

  localparam int N     = spdm_pkg::N_STAGES;
  localparam int LS    = spdm_pkg::LOG_STAGES;
  localparam int EXP_W = $clog2(SAMPLE_WIDTH);

  // ---------------------------------------------------------------------------
  // Pipeline occupancy. Stage 0 holds captured peaks, stage N-1 is the output
  // register. A stage may load when it is empty or something downstream of it
  // frees up, so bubbles collapse while the output is stalled.
  // ---------------------------------------------------------------------------
  logic [N-1:0] v_r;
  logic [N-1:0] v_nxt;
  logic [N-1:0] free;

  for (genvar i = 0; i < N; i++) begin : g_free
    assign free[i] = out_ch.ready | ~(&v_r[N-1:i]);
  end

  logic in_acc;
  assign in_ch.ready = free[0];
  assign in_acc      = in_ch.valid & free[0];

  always_comb begin
    v_nxt[0] = free[0] ? (in_ch.valid & in_ch.last_in_block) : v_r[0];
    for (int i = 1; i < N; i++) begin
      v_nxt[i] = free[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Running peaks. The most negative sample negates to 2^(W-1), which still
  // fits the unsigned magnitude.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_WIDTH-1:0] mag_l, mag_r;
  logic [SAMPLE_WIDTH-1:0] max_l, max_r;
  logic [SAMPLE_WIDTH-1:0] peak_l_r, peak_r_r;
  logic [SAMPLE_WIDTH-1:0] peak_l_nxt, peak_r_nxt;
  logic [SAMPLE_WIDTH-1:0] cap_l_r, cap_r_r;

  always_comb begin
    mag_l = in_ch.left_sample[SAMPLE_WIDTH-1]
          ? (~SAMPLE_WIDTH'(in_ch.left_sample) + 1'b1) : SAMPLE_WIDTH'(in_ch.left_sample);
    mag_r = in_ch.right_sample[SAMPLE_WIDTH-1]
          ? (~SAMPLE_WIDTH'(in_ch.right_sample) + 1'b1) : SAMPLE_WIDTH'(in_ch.right_sample);
    max_l = (mag_l > peak_l_r) ? mag_l : peak_l_r;
    max_r = (mag_r > peak_r_r) ? mag_r : peak_r_r;
    // Hold unless a transaction lands; clear once the block closes.
    peak_l_nxt = peak_l_r;
    peak_r_nxt = peak_r_r;
    if (in_acc) begin
      peak_l_nxt = in_ch.last_in_block ? '0 : max_l;
      peak_r_nxt = in_ch.last_in_block ? '0 : max_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_l_r <= '0;
      peak_r_r <= '0;
    end else begin
      peak_l_r <= peak_l_nxt;
      peak_r_r <= peak_r_nxt;
    end
  end

  // Capture the closing peaks; the valid bit decides whether they count.
  always_ff @(posedge clk) begin
    if (free[0]) begin
      cap_l_r <= max_l;
      cap_r_r <= max_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-channel datapath: log2 then level/segments.
  // ---------------------------------------------------------------------------
  logic                           zero_l, zero_r;
  logic [EXP_W-1:0]               exp_l, exp_r;
  logic [spdm_pkg::FRAC_BITS-1:0] frac_l, frac_r;

  spdm_log2 #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_log_l (
    .clk    (clk),
    .en     (free[LS:1]),
    .peak   (cap_l_r),
    .zero   (zero_l),
    .exp_o  (exp_l),
    .frac_o (frac_l)
  );

  spdm_log2 #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_log_r (
    .clk    (clk),
    .en     (free[LS:1]),
    .peak   (cap_r_r),
    .zero   (zero_r),
    .exp_o  (exp_r),
    .frac_o (frac_r)
  );

  spdm_level #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .SEGMENTS(SEGMENTS)) u_lvl_l (
    .clk    (clk),
    .en     (free[N-1:LS+1]),
    .zero   (zero_l),
    .exp_i  (exp_l),
    .frac_i (frac_l),
    .level  (out_ch.left_level),
    .segs   (out_ch.left_lit_segments)
  );

  spdm_level #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .SEGMENTS(SEGMENTS)) u_lvl_r (
    .clk    (clk),
    .en     (free[N-1:LS+1]),
    .zero   (zero_r),
    .exp_i  (exp_r),
    .frac_i (frac_r),
    .level  (out_ch.right_level),
    .segs   (out_ch.right_lit_segments)
  );

  assign out_ch.valid = v_r[N-1];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_launch_mid_block: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_ch.last_in_block) |=> !v_r[0])
    else $error("capture stage filled by a pair that does not close a block");

  a_peak_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.last_in_block) |=> (peak_l_r == '0 && peak_r_r == '0))
    else $error("peaks not cleared after a block closed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[0] |-> in_ch.ready)
    else $error("input stalled with an empty capture stage");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.left_level <= 10'(spdm_pkg::LEVEL_MAX) &&
                      out_ch.right_level <= 10'(spdm_pkg::LEVEL_MAX)))
    else $error("level reading above full scale");

  a_floor_unlit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.left_level == '0) |-> (out_ch.left_lit_segments == '0))
    else $error("segments lit at the floor level");

endmodule

FILE: rtl/spdm_log2.sv
// Pipelined Q16 log2: leading-one normalize, then one squaring stage per fraction bit.
module spdm_log2 #(
  parameter int SAMPLE_WIDTH = spdm_pkg::SAMPLE_WIDTH,
  localparam int EXP_W = $clog2(SAMPLE_WIDTH)
) (
  input  logic                          clk,
  input  logic [spdm_pkg::LOG_STAGES-1:0] en,
  input  logic [SAMPLE_WIDTH-1:0]       peak,
  output logic                          zero,
  output logic [EXP_W-1:0]              exp_o,
  output logic [spdm_pkg::FRAC_BITS-1:0] frac_o
);

  localparam int MW = spdm_pkg::MANT_W;
  localparam int FB = spdm_pkg::FRAC_BITS;

  logic            zero_r [0:FB];
  logic [EXP_W-1:0] exp_r [0:FB];
  logic [MW-1:0]   m_r    [0:FB];
  logic [FB-1:0]   frac_r [0:FB];

  // Normalize: find leading one, place it at bit 30.
  logic [EXP_W-1:0]          e_nxt;
  logic [SAMPLE_WIDTH+29:0]  ext;
  logic [SAMPLE_WIDTH+29:0]  shifted;

  always_comb begin
    e_nxt = '0;
    for (int i = 0; i < SAMPLE_WIDTH; i++) begin
      if (peak[i]) e_nxt = EXP_W'(i);
    end
    ext     = {peak, 30'b0};
    shifted = ext >> e_nxt;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      zero_r[0] <= (peak == '0);
      exp_r[0]  <= e_nxt;
      m_r[0]    <= shifted[MW-1:0];
      frac_r[0] <= '0;
    end
  end

  // Square, and halve when the square reaches 2.0; that decision is the next bit.
  for (genvar k = 0; k < FB; k++) begin : g_sq
    logic [2*MW-1:0] sq;
    logic [MW:0]     t;
    logic            bit_k;
    logic [MW-1:0]   m_nxt;
    logic [FB-1:0]   frac_nxt;

    always_comb begin
      sq    = m_r[k] * m_r[k];
      t     = sq[2*MW-1:MW-1];
      bit_k = t[MW];
      m_nxt = bit_k ? t[MW:1] : t[MW-1:0];
      frac_nxt = frac_r[k];
      frac_nxt[FB-1-k] = bit_k;
    end

    always_ff @(posedge clk) begin
      if (en[k+1]) begin
        zero_r[k+1] <= zero_r[k];
        exp_r[k+1]  <= exp_r[k];
        m_r[k+1]    <= m_nxt;
        frac_r[k+1] <= frac_nxt;
      end
    end
  end

  assign zero   = zero_r[FB];
  assign exp_o  = exp_r[FB];
  assign frac_o = frac_r[FB];

endmodule

FILE: rtl/spdm_level.sv
// Log2 to clamped 1/16 dB level and lit segment count, three pipeline stages.
module spdm_level #(
  parameter int SAMPLE_WIDTH = spdm_pkg::SAMPLE_WIDTH,
  parameter int SEGMENTS     = spdm_pkg::SEGMENTS,
  localparam int EXP_W = $clog2(SAMPLE_WIDTH)
) (
  input  logic                           clk,
  input  logic [spdm_pkg::LVL_STAGES-1:0] en,
  input  logic                           zero,
  input  logic [EXP_W-1:0]               exp_i,
  input  logic [spdm_pkg::FRAC_BITS-1:0] frac_i,
  output logic [spdm_pkg::LEVEL_W-1:0]   level,
  output logic [spdm_pkg::SEG_W-1:0]     segs
);

  localparam int L_W    = EXP_W + spdm_pkg::FRAC_BITS;
  localparam int PROD_W = L_W + spdm_pkg::DB_SCALE_W;
  localparam int A16_W  = PROD_W + 1 - 32;
  localparam int LW     = spdm_pkg::LEVEL_W;
  localparam logic [L_W-1:0] TOP_L =
    L_W'((SAMPLE_WIDTH - 1) * (2 ** spdm_pkg::FRAC_BITS));
  localparam int SEG_MUL_I = SEGMENTS * spdm_pkg::SEG_RECIP;
  localparam int SM_W      = $clog2(SEG_MUL_I + 1);
  localparam logic [SM_W-1:0] SEG_MUL = SM_W'(SEG_MUL_I);
  localparam logic [LW-1:0]   LVL_MAX = LW'(spdm_pkg::LEVEL_MAX);

  // Stage A: attenuation below full scale, scaled to 1/16 dB in Q32.
  logic [L_W-1:0]    l_val;
  logic [L_W-1:0]    att;
  logic [PROD_W-1:0] prod_nxt;
  logic [PROD_W-1:0] prod_r;
  logic              zero_r;

  always_comb begin
    l_val    = {exp_i, frac_i};
    att      = (l_val >= TOP_L) ? '0 : (TOP_L - l_val);
    prod_nxt = att * spdm_pkg::DB_Q16_SCALE;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r <= prod_nxt;
      zero_r <= zero;
    end
  end

  // Stage B: round the attenuation up, clamp at the floor.
  logic [PROD_W:0]  sum;
  logic [A16_W-1:0] att16;
  logic [LW-1:0]    level_nxt;
  logic [LW-1:0]    level_b_r;

  always_comb begin
    sum   = {1'b0, prod_r} + (PROD_W+1)'(32'hFFFF_FFFF);
    att16 = A16_W'(sum >> 32);
    if (zero_r || (att16 >= A16_W'(spdm_pkg::LEVEL_MAX))) level_nxt = '0;
    else level_nxt = LVL_MAX - att16[LW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) level_b_r <= level_nxt;
  end

  // Stage C: segments = floor(level * SEGMENTS / 960) by reciprocal multiply.
  logic [LW+SM_W-1:0]         seg_prod;
  logic [spdm_pkg::SEG_W-1:0] seg_nxt;
  logic [LW-1:0]              level_c_r;
  logic [spdm_pkg::SEG_W-1:0] seg_c_r;

  always_comb begin
    seg_prod = level_b_r * SEG_MUL;
    seg_nxt  = spdm_pkg::SEG_W'(seg_prod >> spdm_pkg::SEG_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      level_c_r <= level_b_r;
      seg_c_r   <= seg_nxt;
    end
  end

  assign level = level_c_r;
  assign segs  = seg_c_r;

endmodule
